/* src/hrwa_pkg.sv */
// Shared constants, codes and types of the heart-rate window averager.
`timescale 1ns / 1ps

package hrwa_pkg;

  // Ring depth: number of readings that enter the mean.
  localparam int WINDOW = 10;

  localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = $clog2(WINDOW * 255 + 1);
  localparam int STEP_W = $clog2(SUM_W + 1);

  localparam int RATE_W    = 8;
  localparam int REG_W     = 15;
  localparam int CFG_IDX_W = 2;

  localparam logic [REG_W-1:0] COUNT_MAX     = 15'h7fff;
  localparam logic [REG_W-1:0] WAIT_RESET    = 15'd320;
  localparam logic [REG_W-1:0] TIMEOUT_RESET = 15'd600;

  localparam logic [CFG_IDX_W-1:0] CFG_WAIT_TICKS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd1;

  typedef enum logic [1:0] {
    STAT_WAITING   = 2'd0,
    STAT_MEASURING = 2'd1,
    STAT_SUCCESS   = 2'd2,
    STAT_TIMEOUT   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DIV,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

endpackage

/* src/hrwa_ring_ram.sv */
// Reading ring: synchronous memory, one write and one registered read port.
`timescale 1ns / 1ps

module hrwa_ring_ram (
  input  logic                        clk,
  input  logic                        we,
  input  logic [hrwa_pkg::IDX_W-1:0]  waddr,
  input  logic [hrwa_pkg::RATE_W-1:0] wdata,
  input  logic                        re,
  input  logic [hrwa_pkg::IDX_W-1:0]  raddr,
  output logic [hrwa_pkg::RATE_W-1:0] rdata
);
  import hrwa_pkg::*;

  logic [RATE_W-1:0] mem [WINDOW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/hrwa_div.sv */
// Restoring divider: ring sum over entry count, one quotient bit per cycle.
`timescale 1ns / 1ps

module hrwa_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  hrwa_pkg::div_req_t          req,
  output logic                        done,
  output logic [hrwa_pkg::RATE_W-1:0] quotient
);
  import hrwa_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  div_r;
  logic [SUM_W-1:0]  quo_r;

  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              ge;

  always_comb begin
    trial = {rem_r, quo_r[SUM_W-1]};
    diff  = trial - {1'b0, div_r};
    ge    = (trial >= {1'b0, div_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(SUM_W);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Shift dividend bits out at the top and quotient bits in at the bottom.
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      div_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      quo_r <= {quo_r[SUM_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r[RATE_W-1:0];

endmodule

/* src/heart_rate_window_averager_core.sv */
// Top level of the heart-rate window averager: tick control, ring and mean.
`timescale 1ns / 1ps

// Channel | ports                                             | direction
// tick    | in_valid, in_stall, in_sample_ready, in_rate_sample | in
// result  | out_valid, out_stall, out_status,                 | out
//         | out_discard_reading, out_latest_rate, out_average_rate |
// config  | cfg_we, cfg_index, cfg_wdata                      | in
//
// A tick that stores a reading passes accept, ring read, the restoring
// divider steps and result hand-off; any other tick goes from accept
// straight to the hand-off.
// Reset is synchronous and restores the tick limits to 320 and 600; the
// ring itself is not cleared, since only written entries enter the sum.
// A stalled result holds in the output register; the next tick is taken
// meanwhile and its result waits in the pending stage.

module heart_rate_window_averager_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_sample_ready,
  input  logic [hrwa_pkg::RATE_W-1:0]    in_rate_sample,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_status,
  output logic                           out_discard_reading,
  output logic [hrwa_pkg::RATE_W-1:0]    out_latest_rate,
  output logic [hrwa_pkg::RATE_W-1:0]    out_average_rate,
  input  logic                           cfg_we,
  input  logic [hrwa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hrwa_pkg::REG_W-1:0]     cfg_wdata
);
  import hrwa_pkg::*;

  state_t            state_r, state_nxt;

  logic [REG_W-1:0]  wait_r;
  logic [REG_W-1:0]  timeout_r;
  logic [REG_W-1:0]  elapsed_r;
  logic [IDX_W-1:0]  slot_r;
  logic              full_r;
  logic [SUM_W-1:0]  sum_r;
  logic [RATE_W-1:0] latest_r;
  logic [RATE_W-1:0] avg_r;
  status_t           pend_status_r;
  logic              pend_discard_r;

  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic              out_discard_r;
  logic [RATE_W-1:0] out_latest_r;
  logic [RATE_W-1:0] out_avg_r;

  // Tick decision
  logic              accept;
  logic              waiting;
  logic              store;
  logic              timeout;

  // Ring update
  logic [RATE_W-1:0] ram_rdata;
  logic [IDX_W:0]    slot_inc;
  logic              wrap;
  logic              full_nxt;
  logic [IDX_W-1:0]  slot_nxt;
  logic [CNT_W-1:0]  count_nxt;
  logic [SUM_W-1:0]  sum_nxt;
  logic [SUM_W-1:0]  old_entry;

  // Control outputs of the sequencer
  logic              idle;
  logic              ram_re;
  logic              ram_we;
  logic              load_out;
  logic              out_free;

  div_req_t          div_req;
  logic              div_done;
  logic [RATE_W-1:0] div_quo;

  assign accept  = in_valid && !in_stall;
  assign waiting = (elapsed_r < wait_r);
  assign store   = !waiting && in_sample_ready;
  assign timeout = !waiting && !in_sample_ready && (elapsed_r > timeout_r);

  // Advance the write slot; wrap at the window and mark the ring full.
  always_comb begin
    slot_inc  = {1'b0, slot_r} + 1'b1;
    wrap      = (slot_inc >= (IDX_W+1)'(WINDOW));
    full_nxt  = full_r || wrap;
    slot_nxt  = wrap ? '0 : slot_inc[IDX_W-1:0];
    count_nxt = full_nxt ? CNT_W'(WINDOW) : slot_inc[CNT_W-1:0];
    // Entry being overwritten leaves the sum only once the ring is full.
    old_entry = full_r ? SUM_W'(ram_rdata) : '0;
    sum_nxt   = sum_r - old_entry + SUM_W'(latest_r);
  end

  assign out_free = !out_valid_r || !out_stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = store ? S_READ : S_EMIT;
        end
      end
      S_READ: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Sequencer outputs
  always_comb begin
    idle     = 1'b0;
    ram_re   = 1'b0;
    ram_we   = 1'b0;
    load_out = 1'b0;
    case (state_r)
      S_IDLE: begin
        idle   = 1'b1;
        ram_re = accept && store;
      end
      S_READ: begin
        ram_we = 1'b1;
      end
      S_DIV: begin
      end
      S_EMIT: begin
        load_out = out_free;
      end
      default: begin
      end
    endcase
  end

  assign in_stall = !idle;

  always_comb begin
    div_req.start    = ram_we;
    div_req.dividend = sum_nxt;
    div_req.divisor  = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Tick limits: the user must write them only while idle; the block itself does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wait_r    <= WAIT_RESET;
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WAIT_TICKS:    wait_r    <= cfg_wdata;
        CFG_TIMEOUT_TICKS: timeout_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Measurement state: counter, slot, running sum and held readings.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r      <= '0;
      slot_r         <= '0;
      full_r         <= 1'b0;
      sum_r          <= '0;
      latest_r       <= '0;
      avg_r          <= '0;
      pend_status_r  <= STAT_WAITING;
      pend_discard_r <= 1'b0;
    end else begin
      if (accept) begin
        // Restart on success or failure; otherwise count up and saturate.
        if (store || timeout) begin
          elapsed_r <= '0;
        end else if (elapsed_r != COUNT_MAX) begin
          elapsed_r <= elapsed_r + 1'b1;
        end
        pend_discard_r <= waiting;
        if (waiting) begin
          pend_status_r <= STAT_WAITING;
        end else if (store) begin
          pend_status_r <= STAT_SUCCESS;
          latest_r      <= in_rate_sample;
        end else if (timeout) begin
          pend_status_r <= STAT_TIMEOUT;
        end else begin
          pend_status_r <= STAT_MEASURING;
        end
      end
      if (ram_we) begin
        slot_r <= slot_nxt;
        full_r <= full_nxt;
        sum_r  <= sum_nxt;
      end
      if (div_done) begin
        avg_r <= div_quo;
      end
    end
  end

  // Output register: hold while stalled, drop once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r  <= pend_status_r;
      out_discard_r <= pend_discard_r;
      out_latest_r  <= latest_r;
      out_avg_r     <= avg_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_discard_reading = out_discard_r;
  assign out_latest_rate     = out_latest_r;
  assign out_average_rate    = out_avg_r;

  // Read the entry at the slot on accept, write the new reading next cycle.
  hrwa_ring_ram u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata (latest_r),
    .re    (ram_re),
    .raddr (slot_r),
    .rdata (ram_rdata)
  );

  hrwa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quo)
  );

endmodule

/* src/hrwa_checker.sv */
// Port-level assertions for the heart-rate window averager, bound to the top.
`timescale 1ns / 1ps

module hrwa_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [1:0]                     out_status,
  input logic                           out_discard_reading,
  input logic [hrwa_pkg::RATE_W-1:0]    out_latest_rate,
  input logic [hrwa_pkg::RATE_W-1:0]    out_average_rate
);
  import hrwa_pkg::*;

  // A stalled result transaction holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_discard_reading) && $stable(out_latest_rate)
      && $stable(out_average_rate))
    else $error("stalled result changed");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Discard is asked for exactly while waiting.
  a_discard: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_status == STAT_WAITING) == out_discard_reading))
    else $error("discard flag disagrees with status");

  // One tick at a time: an accepted tick keeps the input stalled next cycle.
  a_one_tick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("tick accepted while previous one in work");

endmodule

bind heart_rate_window_averager_core hrwa_checker u_hrwa_checker (.*);

/* sim/heart_rate_window_averager_core_test.sv */
// Self-checking testbench of the heart-rate window averager core.
`timescale 1ns / 1ps

typedef struct packed {
  hrwa_pkg::status_t           status;
  logic                        discard;
  logic [hrwa_pkg::RATE_W-1:0] latest;
  logic [hrwa_pkg::RATE_W-1:0] average;
} tick_result_t;

// Tracks the tick counter, the reading ring and the tick limits, and keeps
// the expected result of every accepted tick in arrival order.
class tick_scoreboard;
  bit [hrwa_pkg::REG_W-1:0]  wait_limit;
  bit [hrwa_pkg::REG_W-1:0]  timeout_limit;
  bit [hrwa_pkg::REG_W-1:0]  tick_count;
  bit [hrwa_pkg::RATE_W-1:0] readings [hrwa_pkg::WINDOW];
  int unsigned               next_slot;
  bit                        wrapped;
  bit [hrwa_pkg::RATE_W-1:0] last_rate;
  bit [hrwa_pkg::RATE_W-1:0] mean_rate;
  tick_result_t              expected_q [$];
  int unsigned               mismatches;

  function new();
    wait_limit    = hrwa_pkg::WAIT_RESET;
    timeout_limit = hrwa_pkg::TIMEOUT_RESET;
    tick_count    = '0;
    next_slot     = 0;
    wrapped       = 1'b0;
    last_rate     = '0;
    mean_rate     = '0;
    mismatches    = 0;
  endfunction

  function void write_limit(logic [hrwa_pkg::CFG_IDX_W-1:0] index,
                            logic [hrwa_pkg::REG_W-1:0] value);
    case (index)
      hrwa_pkg::CFG_WAIT_TICKS:    wait_limit = value;
      hrwa_pkg::CFG_TIMEOUT_TICKS: timeout_limit = value;
      default: ;
    endcase
  endfunction

  function void note_tick(bit ready, bit [hrwa_pkg::RATE_W-1:0] rate);
    tick_result_t r;
    bit           restart;
    int unsigned  depth;
    int unsigned  sum;
    restart   = 1'b0;
    r.discard = 1'b0;
    if (tick_count < wait_limit) begin
      r.status  = hrwa_pkg::STAT_WAITING;
      r.discard = 1'b1;
    end else if (ready) begin
      last_rate = rate;
      readings[next_slot] = rate;
      if (next_slot == hrwa_pkg::WINDOW - 1) begin
        next_slot = 0;
        wrapped   = 1'b1;
      end else begin
        next_slot++;
      end
      depth = wrapped ? hrwa_pkg::WINDOW : next_slot;
      sum   = 0;
      for (int k = 0; k < depth; k++) sum += readings[k];
      mean_rate = 8'(sum / depth);
      r.status  = hrwa_pkg::STAT_SUCCESS;
      restart   = 1'b1;
    end else if (tick_count > timeout_limit) begin
      r.status = hrwa_pkg::STAT_TIMEOUT;
      restart  = 1'b1;
    end else begin
      r.status = hrwa_pkg::STAT_MEASURING;
    end
    if (restart) tick_count = '0;
    else if (tick_count != hrwa_pkg::COUNT_MAX) tick_count++;
    r.latest  = last_rate;
    r.average = mean_rate;
    expected_q.push_back(r);
  endfunction

  function void check_result(logic [1:0] status, logic discard,
                             logic [hrwa_pkg::RATE_W-1:0] latest,
                             logic [hrwa_pkg::RATE_W-1:0] average);
    tick_result_t e;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: status %0d discard %0d latest %0d average %0d",
                 status, discard, latest, average);
      return;
    end
    e = expected_q.pop_front();
    if (status !== e.status || discard !== e.discard ||
        latest !== e.latest || average !== e.average) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch (exp/act): st %0d/%0d dis %0d/%0d lat %0d/%0d avg %0d/%0d",
                 e.status, status, e.discard, discard, e.latest, latest,
                 e.average, average);
    end
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction

  function int unsigned failures();
    return mismatches + expected_q.size();
  endfunction
endclass

module heart_rate_window_averager_core_test;
  import hrwa_pkg::*;

  // Settle time covers a stored reading's ring read, divider and hand-off, with margin.
  localparam int          SETTLE_CYCLES     = 2 * (SUM_W + 4);
  localparam int unsigned CYCLE_LIMIT       = 2_000_000;
  localparam int          HOLD_CYCLES       = 400;
  localparam int          RESET_PHASE_TICKS = 330;
  localparam int          RANDOM_PHASES     = 6;
  localparam int          PHASE_TICKS       = 60;
  // Index with no register behind it: writes must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_sample_ready;
  logic [RATE_W-1:0]    in_rate_sample;
  logic                 out_valid;
  logic                 out_stall;
  logic [1:0]           out_status;
  logic                 out_discard_reading;
  logic [RATE_W-1:0]    out_latest_rate;
  logic [RATE_W-1:0]    out_average_rate;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0]     cfg_wdata;

  tick_scoreboard sb;
  bit             idle_on;        // random idling on both channels
  int unsigned    hold_requests;  // bumped by the stimulus to ask for a long hold-off
  int unsigned    hold_served;
  int unsigned    hold_left;
  int unsigned    stall_left;
  int unsigned    cycle_count;

  heart_rate_window_averager_core uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_sample_ready     (in_sample_ready),
    .in_rate_sample      (in_rate_sample),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_discard_reading (out_discard_reading),
    .out_latest_rate     (out_latest_rate),
    .out_average_rate    (out_average_rate),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result side: check each transaction taken at this edge, then pick the
  // stall level for the next cycle. A pending hold-off request wins over
  // the random bursts.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_status, out_discard_reading, out_latest_rate, out_average_rate);
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (idle_on && stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_stall  <= 1'b1;
      stall_left = $urandom_range(1, 19) - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Offer one tick, maybe after a random gap, and hold it until taken.
  // Leave valid high so back-to-back ticks need no second assignment.
  task automatic send_tick(bit ready, bit [RATE_W-1:0] rate);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = int'($urandom_range(1, 19));
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_sample_ready <= ready;
    in_rate_sample  <= rate;
    do @(posedge clk); while (in_stall);
    sb.note_tick(ready, rate);
  endtask

  // Write one tick limit; only called while the block is idle.
  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [REG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_limit(index, value);
    @(posedge clk);
  endtask

  // Stop offering, wait for every outstanding result, then let the
  // pipeline run dry.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random ticks; extremes of the reading turn up often.
  task automatic run_phase(int ticks, int ready_pct);
    bit              ready;
    bit [RATE_W-1:0] rate;
    for (int i = 0; i < ticks; i++) begin
      ready = ($urandom_range(0, 99) < ready_pct);
      case ($urandom_range(0, 7))
        0:       rate = 8'h00;
        1:       rate = 8'hff;
        default: rate = RATE_W'($urandom_range(0, 255));
      endcase
      send_tick(ready, rate);
    end
  endtask

  initial begin
    in_valid        = 1'b0;
    in_sample_ready = 1'b0;
    in_rate_sample  = '0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_WAIT_TICKS;
    cfg_wdata       = '0;
    out_stall       = 1'b0;
    rst_n           = 1'b0;
    idle_on         = 1'b1;
    sb              = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset limits: 320 waiting ticks with discard, then measuring or success.
    run_phase(RESET_PHASE_TICKS, 50);
    settle();

    // Short limits: ready readings dropped while waiting, one success,
    // then a timeout once the count passes three.
    write_reg(CFG_WAIT_TICKS, 15'd2);
    write_reg(CFG_TIMEOUT_TICKS, 15'd3);
    send_tick(1'b1, 8'hff);
    send_tick(1'b1, 8'h00);
    send_tick(1'b0, 8'hff);
    send_tick(1'b1, 8'hff);
    repeat (5) send_tick(1'b0, 8'h00);
    settle();

    // Zero limits: timeout on the second idle tick; fill and wrap the ring
    // with extreme readings. The spare index must not touch either limit.
    write_reg(CFG_WAIT_TICKS, 15'd0);
    write_reg(CFG_TIMEOUT_TICKS, 15'd0);
    write_reg(CFG_SPARE, 15'h7fff);
    send_tick(1'b0, 8'h55);
    send_tick(1'b0, 8'haa);
    for (int k = 0; k < 11; k++) send_tick(1'b1, (k == 3) ? 8'h00 : 8'hff);
    settle();

    // Random limits kept small so success and timeout come often. One
    // phase gets a long result hold-off while ticks keep coming.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      idle_on = (p % 3 != 2);
      write_reg(CFG_WAIT_TICKS, REG_W'($urandom_range(0, 8)));
      write_reg(CFG_TIMEOUT_TICKS, REG_W'($urandom_range(0, 20)));
      if (p == 1) hold_requests++;
      run_phase(PHASE_TICKS, int'($urandom_range(10, 90)));
      settle();
    end

    // Last part, no idling: timeout limit at the top, so a long run of
    // empty ticks never fails; then ready ticks, with waits after each success.
    idle_on = 1'b0;
    write_reg(CFG_WAIT_TICKS, 15'd5);
    write_reg(CFG_TIMEOUT_TICKS, COUNT_MAX);
    repeat (70) send_tick(1'b0, RATE_W'($urandom_range(0, 255)));
    repeat (12) send_tick(1'b1, RATE_W'($urandom_range(0, 255)));
    settle();

    if (sb.failures() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* files.f */
src/hrwa_pkg.sv
src/hrwa_ring_ram.sv
src/hrwa_div.sv
src/heart_rate_window_averager_core.sv
src/hrwa_checker.sv
sim/heart_rate_window_averager_core_test.sv
